// ===== rtl/pflet_pkg.sv =====
// Shared types and constants for the prime-field log/exp table builder.
`timescale 1ns / 1ps
package pflet_pkg;
	localparam int VW = 10;
	localparam logic [1:0] OP_BUILD = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_REXP = 2'd2;
	localparam logic [1:0] OP_RLOG = 2'd3;
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOT_PRIME = 3'd1;
	localparam logic [2:0] ST_NOT_PRIMITIVE = 3'd2;
	localparam logic [2:0] ST_NONE_FOUND = 3'd3;
	localparam logic [2:0] ST_NOT_BUILT = 3'd4;
	localparam logic [2:0] ST_RANGE = 3'd5;

	// request/handshake to the bit-serial modular multiply unit
	typedef struct packed {
		logic          start;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
		logic [VW-1:0] m;
	} mm_req_t;

	typedef struct packed {
		logic          done;
		logic [VW-1:0] r;
	} mm_rsp_t;
endpackage

// ===== rtl/pflet_mulmod.sv =====
// Bit-serial modular multiply and remainder unit: one bit of b per cycle.
`timescale 1ns / 1ps
module pflet_mulmod import pflet_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);
	// r = (a*b) mod m by double-and-add from the msb of b; b mod m comes out with a=1
	logic [VW:0]   acc_q;
	logic [VW-1:0] a_q, b_q, m_q;
	logic [3:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW+1:0] dbl, add;
	logic [VW:0]   dbl_r, add_r;

	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_r = (dbl >= {2'b0, m_q}) ? VW'(0) + (VW+1)'(dbl - {2'b0, m_q})
			: (VW+1)'(dbl);
		add = {1'b0, dbl_r} + (b_q[VW-1] ? {2'b0, a_q} : '0);
		add_r = (add >= {2'b0, m_q}) ? (VW+1)'(add - {2'b0, m_q}) : (VW+1)'(add);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(VW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// a must already be below m; the accumulator then stays below m every step
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
			m_q <= req.m;
		end else if (busy_q) begin
			acc_q <= add_r;
			b_q <= {b_q[VW-2:0], 1'b0};
		end
	end
	assign rsp = {done_q, acc_q[VW-1:0]};
endmodule

// ===== rtl/prime_field_log_exp_table_builder.sv =====
// Top level: config port, build sequencer, table memories and stream ports.
// Reads: the result is registered through S_RD and S_RD2 before S_OUT; one word at a
// time, the next is taken once the result has left. A build runs the trial divisors,
// then a seen-map clear and the powers of each tested element, then the table fill;
// search may test up to p-2 elements.
// The shared bit-serial multiply unit does every division, reduction and product.
// arst_n clears control state, built size and generator; tables stay undefined.
`timescale 1ns / 1ps
module prime_field_log_exp_table_builder import pflet_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // op[1:0], element[11:2], index[21:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // status[2:0], value[12:3], generator[22:13]
);
	localparam int AW = $clog2(MAX_ELEMENTS);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001, S_DIV = 11'b00000000010, S_DIVW = 11'b00000000100,
		S_CLR = 11'b00000001000, S_TMUL = 11'b00000010000, S_TCHK = 11'b00000100000,
		S_FMUL = 11'b00001000000, S_FWR = 11'b00010000000, S_RD = 11'b00100000000,
		S_RD2 = 11'b01000000000, S_OUT = 11'b10000000000
	} state_t;

	state_t        state_q;
	logic [VW-1:0] pmod_q, p_q, d_q, g_q, acc_q, k_q, built_q, gen_q, idx_q, val_q;
	logic [1:0]    op_q;
	logic [2:0]    st_q;
	logic          ovalid_q, seen_rd_q, rlog_q;
	mm_req_t       mreq;
	mm_rsp_t       mrsp;

	logic          seen_mem [MAX_ELEMENTS];
	logic [VW-1:0] exp_mem  [MAX_ELEMENTS];
	logic [VW-1:0] log_mem  [MAX_ELEMENTS];
	logic          seen_we, seen_wd;
	logic [AW-1:0] seen_wa;
	logic [VW-1:0] exp_rd_q, log_rd_q;

	pflet_mulmod u_mm (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	assign pready = 1'b1;
	assign prdata = {22'd0, pmod_q};
	assign s_tready = (state_q == S_IDLE) && !ovalid_q;
	assign m_tvalid = ovalid_q;
	assign m_tdata = {1'b0, gen_q, val_q, st_q};

	logic          p_ok;
	assign p_ok = (32'(p_q) <= MAX_ELEMENTS);

	always_comb begin
		mreq = '0;
		mreq.m = p_q;
		seen_we = 1'b0;
		seen_wa = AW'(acc_q);
		seen_wd = 1'b1;
		unique case (state_q)
			// remainder of p by the divisor, or element reduced modulo p once d reaches p
			S_DIV: begin
				mreq.start = 1'b1; mreq.a = 10'd1;
				mreq.b = (d_q == p_q) ? g_q : p_q; mreq.m = d_q;
			end
			S_CLR: begin seen_we = 1'b1; seen_wa = AW'(k_q); seen_wd = (k_q == 10'd1); end
			S_TMUL, S_FMUL: begin mreq.start = 1'b1; mreq.a = acc_q; mreq.b = g_q; end
			default: ;
		endcase
		if (state_q == S_TCHK && mrsp.done) begin
			seen_we = 1'b1;
			seen_wa = AW'(mrsp.r);
		end
	end

	always_ff @(posedge clk) begin
		if (seen_we) seen_mem[seen_wa] <= seen_wd;
		seen_rd_q <= seen_mem[AW'(mrsp.r)];
		exp_rd_q <= exp_mem[AW'(idx_q)];
		log_rd_q <= log_mem[AW'(idx_q)];
		if (state_q == S_FWR && !rlog_q) begin
			exp_mem[AW'(k_q)] <= acc_q;
			if (k_q + 10'd1 < p_q) log_mem[AW'(acc_q)] <= k_q;
			if (k_q == 10'd0) log_mem[0] <= 10'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pmod_q <= 10'd2;
			built_q <= '0;
			gen_q <= '0;
			ovalid_q <= 1'b0;
			op_q <= '0;
			st_q <= ST_OK;
			val_q <= '0;
			p_q <= '0; d_q <= '0; g_q <= '0; acc_q <= '0; k_q <= '0; idx_q <= '0;
			rlog_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && !paddr) pmod_q <= pwdata[VW-1:0];
			if (m_tvalid && m_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_tvalid && s_tready) begin
					op_q <= s_tdata[1:0];
					idx_q <= s_tdata[21:12];
					g_q <= s_tdata[11:2];
					p_q <= pmod_q;
					val_q <= '0;
					st_q <= ST_OK;
					d_q <= 10'd2;
					if (s_tdata[1]) state_q <= S_RD;
					else state_q <= S_DIVW;
				end
				S_DIVW: begin
					// first pass checks range; then trial divisors
					if (!p_ok || p_q < 10'd2) begin
						st_q <= ST_NOT_PRIME; state_q <= S_OUT;
					end else if (d_q >= p_q) begin
						// prime: reduce element for op 0
						d_q <= p_q;
						if (op_q == OP_SEARCH) g_q <= 10'd2;
						state_q <= (op_q == OP_BUILD) ? S_DIV : S_CLR;
						k_q <= '0;
					end else state_q <= S_DIV;
				end
				S_DIV: state_q <= S_TCHK;
				S_TCHK: if (mrsp.done) begin
					if (d_q != p_q && d_q != 10'd0) begin
						// trial division result
						if (mrsp.r == '0) begin st_q <= ST_NOT_PRIME; state_q <= S_OUT; end
						else begin d_q <= d_q + 10'd1; state_q <= S_DIVW; end
					end else if (d_q == p_q) begin
						g_q <= mrsp.r; d_q <= '0; k_q <= '0; state_q <= S_CLR;
					end else begin
						// power step: seen_rd_q reads next cycle, handled in S_FWR
						acc_q <= mrsp.r; k_q <= k_q + 10'd1; state_q <= S_FWR;
						rlog_q <= 1'b1;
					end
				end
				S_CLR: begin
					d_q <= '0;
					if (op_q == OP_SEARCH && g_q >= p_q) begin
						st_q <= ST_NONE_FOUND; state_q <= S_OUT;
					end else if (g_q == '0) begin
						st_q <= ST_NOT_PRIMITIVE; state_q <= S_OUT;
					end else if (k_q == p_q - 10'd1) begin
						k_q <= 10'd2; acc_q <= 10'd1; state_q <= S_TMUL;
					end else k_q <= k_q + 10'd1;
				end
				S_TMUL: begin
					if (k_q >= p_q) begin
						acc_q <= 10'd1; k_q <= '0; rlog_q <= 1'b0; state_q <= S_FWR;
					end else begin
						k_q <= k_q - 10'd1; state_q <= S_TCHK;
					end
				end
				S_FWR: begin
					if (rlog_q) begin
						// test step: seen bit of new power now valid
						rlog_q <= 1'b0;
						if (seen_rd_q) begin
							if (op_q == OP_SEARCH) begin
								g_q <= g_q + 10'd1; k_q <= '0; state_q <= S_CLR;
							end else begin st_q <= ST_NOT_PRIMITIVE; state_q <= S_OUT; end
						end else begin k_q <= k_q + 10'd1; state_q <= S_TMUL; end
					end else if (k_q + 10'd1 >= p_q) begin
						built_q <= p_q; gen_q <= g_q; state_q <= S_OUT;
					end else state_q <= S_FMUL;
				end
				S_FMUL: state_q <= S_RD2;
				S_RD2: begin
					if (op_q[1]) begin
						val_q <= rlog_q ? log_rd_q : exp_rd_q; state_q <= S_OUT;
					end else if (mrsp.done) begin
						acc_q <= mrsp.r; k_q <= k_q + 10'd1; state_q <= S_FWR;
					end
				end
				S_RD: begin
					rlog_q <= (op_q == OP_RLOG);
					if (built_q == '0) begin st_q <= ST_NOT_BUILT; state_q <= S_OUT; end
					else if (idx_q >= built_q) begin st_q <= ST_RANGE; state_q <= S_OUT; end
					else state_q <= S_RD2;
				end
				S_OUT: begin ovalid_q <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result never appears while another is still held
	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> !ovalid_q) else $error("result overwritten");
	// a successful build leaves a nonzero generator
	a_gen: assert property (@(posedge clk) disable iff (!arst_n)
		(built_q != '0) |-> (gen_q != '0)) else $error("build without generator");
	// input only taken when idle and output free
	a_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == S_IDLE && !m_tvalid)) else $error("ready while busy");
endmodule

// ===== dv/pflet_checker.sv =====
// Checker: watches the config port and both streams, predicts each result word and compares.
`timescale 1ns / 1ps
module pflet_checker import pflet_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [31:0] pwdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // op[1:0], element[11:2], index[21:12]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // status[2:0], value[12:3], generator[22:13]
	output int          fail_count,
	output int          pending,
	output int          result_count,
	output int          build_ok_count
);
	localparam int MAX_ELEMENTS = 1024;

	typedef struct packed {
		logic [2:0]    status;
		logic [VW-1:0] value;
		logic [VW-1:0] generator;
	} table_result_t;

	logic [VW-1:0] field_size;
	logic [VW-1:0] exp_tab [MAX_ELEMENTS];
	logic [VW-1:0] log_tab [MAX_ELEMENTS];
	bit            seen [MAX_ELEMENTS];
	int            tab_size;
	logic [VW-1:0] gen_used;
	table_result_t expected_q [$];

	function automatic bit is_prime(int p);
		if (p < 2)
			return 0;
		for (int d = 2; d < p; d++)
			if (p % d == 0)
				return 0;
		return 1;
	endfunction

	function automatic bit is_primitive(int p, int g);
		int acc;
		acc = 1;
		if (g == 0)
			return 0;
		for (int i = 0; i < MAX_ELEMENTS; i++)
			seen[i] = 0;
		seen[1] = 1;
		for (int k = 2; k < p; k++) begin
			acc = (acc * g) % p;
			if (seen[acc])
				return 0;
			seen[acc] = 1;
		end
		return 1;
	endfunction

	function automatic void fill_tables(int p, int g);
		exp_tab[0] = 10'd1;
		for (int k = 1; k < p; k++)
			exp_tab[k] = VW'((int'(exp_tab[k-1]) * g) % p);
		log_tab[0] = 10'd0;
		for (int k = 0; k + 1 < p; k++)
			log_tab[exp_tab[k]] = VW'(k);
		tab_size = p;
		gen_used = VW'(g);
		build_ok_count++;
	endfunction

	function automatic table_result_t predict_word(logic [1:0] op, int el, int ix);
		table_result_t r;
		int p;
		int found;
		r = '0;
		r.status = ST_OK;
		p = field_size;
		if (op == OP_BUILD || op == OP_SEARCH) begin
			if (p > MAX_ELEMENTS || !is_prime(p))
				r.status = ST_NOT_PRIME;
			else if (op == OP_BUILD) begin
				if (is_primitive(p, el % p))
					fill_tables(p, el % p);
				else
					r.status = ST_NOT_PRIMITIVE;
			end else begin
				found = 0;
				for (int c = 2; c < p; c++)
					if (is_primitive(p, c)) begin
						found = c;
						break;
					end
				if (found != 0)
					fill_tables(p, found);
				else
					r.status = ST_NONE_FOUND;
			end
		end else if (tab_size == 0)
			r.status = ST_NOT_BUILT;
		else if (ix >= tab_size)
			r.status = ST_RANGE;
		else if (op == OP_REXP)
			r.value = exp_tab[ix];
		else
			r.value = log_tab[ix];
		r.generator = gen_used;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_result_t exp_r;
		table_result_t got;
		if (!arst_n) begin
			field_size = 10'd2;
			tab_size = 0;
			gen_used = '0;
			fail_count = 0;
			pending = 0;
			result_count = 0;
			build_ok_count = 0;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready)
				field_size = pwdata[VW-1:0];
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_word(s_tdata[1:0], s_tdata[11:2],
					s_tdata[21:12]));
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[2:0];
				got.value = m_tdata[12:3];
				got.generator = m_tdata[22:13];
				result_count++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, m_tdata);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (got.status !== exp_r.status) begin
						$display("%0t: status exp %0d got %0d", $time, exp_r.status,
							got.status);
						fail_count++;
					end
					if (got.value !== exp_r.value) begin
						$display("%0t: value exp %0d got %0d", $time, exp_r.value,
							got.value);
						fail_count++;
					end
					if (got.generator !== exp_r.generator) begin
						$display("%0t: generator exp %0d got %0d", $time,
							exp_r.generator, got.generator);
						fail_count++;
					end
				end
			end
			pending = expected_q.size();
		end
	end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top: clock, reset, config writes, stream stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import pflet_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [23:0] m_tdata;
	logic        s_acc;

	int fail_count, pending, result_count, build_ok_count;
	int idle_pct, stall_pct, hold_req;
	int cur_p, word_count, cfg_count;

	int field_list [] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53,
		59, 61, 9, 1, 0, 15};

	prime_field_log_exp_table_builder u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	pflet_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.pwdata(pwdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending), .result_count(result_count),
		.build_ok_count(build_ok_count)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk)
		s_acc <= s_tvalid && s_tready;

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int seen_req;
		int hold_cnt;
		seen_req = 0;
		hold_cnt = 0;
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_req != seen_req) begin
				seen_req = hold_req;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 0;
			end else
				m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic cfg_write(int p);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= 0;
		pwdata <= p;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		cur_p = p;
		cfg_count++;
	endtask

	task automatic send_word(logic [1:0] op, logic [9:0] el, logic [9:0] ix);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {2'b00, ix, el, op};
		do @(negedge clk); while (!s_acc);
		word_count++;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		s_tvalid <= 0;
		repeat (20) @(negedge clk);
	endtask

	task automatic random_phase(int n);
		int r;
		logic [1:0] op;
		logic [9:0] ix;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			op = (r < 10) ? OP_BUILD : (r < 20) ? OP_SEARCH : (r < 60) ? OP_REXP : OP_RLOG;
			if ($urandom_range(3) == 0)
				ix = 10'($urandom);
			else
				ix = 10'($urandom_range(cur_p));
			send_word(op, 10'($urandom), ix);
		end
		drain();
	endtask

	initial begin
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		s_tvalid = 0; s_tdata = 0;
		idle_pct = 0; stall_pct = 0; hold_req = 0;
		cur_p = 2; word_count = 0; cfg_count = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reads before any build, then modulus two
		send_word(OP_REXP, 0, 0);
		send_word(OP_RLOG, 10'h3FF, 10'h3FF);
		send_word(OP_SEARCH, 0, 0);
		send_word(OP_BUILD, 0, 0);
		send_word(OP_BUILD, 1, 0);
		send_word(OP_REXP, 0, 0);
		send_word(OP_REXP, 0, 1);
		send_word(OP_RLOG, 0, 2);
		drain();
		foreach (field_list[k]) begin
			if (field_list[k] inside {0, 1, 9}) begin
				cfg_write(field_list[k]);
				send_word(OP_BUILD, 3, 0);
				send_word(OP_SEARCH, 0, 0);
				drain();
			end
		end
		cfg_write(1023);
		send_word(OP_BUILD, 10'h3FF, 0);
		drain();
		// modulus seven: zero, small order, primitive, reduced element
		cfg_write(7);
		send_word(OP_BUILD, 7, 0);
		send_word(OP_BUILD, 2, 0);
		send_word(OP_BUILD, 3, 0);
		send_word(OP_BUILD, 10, 0);
		send_word(OP_SEARCH, 0, 0);
		send_word(OP_REXP, 0, 6);
		send_word(OP_RLOG, 0, 0);
		send_word(OP_RLOG, 0, 6);
		send_word(OP_REXP, 0, 7);
		drain();
		// reads use the last build's size, not the new register value
		cfg_write(3);
		send_word(OP_REXP, 0, 6);
		send_word(OP_BUILD, 3, 0);
		drain();

		// random phases across moduli and idling modes
		for (int ph = 0; ph < 8; ph++) begin
			cfg_write(field_list[$urandom_range(field_list.size() - 1)]);
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 76; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 76; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			if (ph == 4)
				hold_req++;
			send_word(OP_SEARCH, 0, 0);
			random_phase(32);
		end

		// largest prime that fits once
		idle_pct = 0; stall_pct = 0;
		cfg_write(1021);
		send_word(OP_BUILD, 10, 0);
		send_word(OP_SEARCH, 0, 0);
		random_phase(12);
		cfg_write(2);
		random_phase(6);

		repeat (50) @(negedge clk);
		$display("Covered %0d words over %0d modulus settings, %0d good builds.",
			word_count, cfg_count, build_ok_count);
		$display("Checked %0d result words under mixed idle and stall phases.",
			result_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
